### rtl/core/ttcp_pkg.sv
// shared constants, types and helpers for the triangle transform, cull and project pipeline
package ttcp_pkg;

    localparam int unsigned SCREEN_W_DEF = 256;
    localparam int unsigned SCREEN_H_DEF = 240;

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_Z   = 3'd0,
        REG_SIN_Z   = 3'd1,
        REG_COS_X   = 3'd2,
        REG_SIN_X   = 3'd3,
        REG_PROJ_X  = 3'd4,
        REG_PROJ_Y  = 3'd5,
        REG_DEPTH   = 3'd6,
        REG_UNUSED  = 3'd7
    } cfg_reg_t;

    localparam logic signed [15:0] COS_Z_RST = 16'sd16384;
    localparam logic signed [15:0] SIN_Z_RST = 16'sd0;
    localparam logic signed [15:0] COS_X_RST = 16'sd16384;
    localparam logic signed [15:0] SIN_X_RST = 16'sd0;
    localparam logic signed [15:0] PROJ_X_RST = 16'sd3840;
    localparam logic signed [15:0] PROJ_Y_RST = 16'sd4096;
    localparam logic signed [15:0] DEPTH_RST = 16'sd12288;

    // rotated x/y fit in 20 bits signed after both rotations; rotated z plus offset fits 20 bits
    localparam int unsigned ROT_W = 20;
    localparam int unsigned Z_W = 20;

    // 16-bit saturation of a wide signed value
    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        logic signed [15:0] r;
        begin
            if (v > 48'sd32767)
                r = 16'sh7fff;
            else if (v < -48'sd32768)
                r = 16'sh8000;
            else
                r = v[15:0];
            return r;
        end
    endfunction

endpackage

### rtl/core/ttcp_div.sv
// pipelined signed divider, one quotient bit per stage, truncates toward zero
module ttcp_div #(
    parameter int unsigned NUM_W = 48,
    parameter int unsigned DEN_W = 34,
    parameter int unsigned TAG_W = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic signed [NUM_W-1:0]  num,
    input  logic signed [DEN_W-1:0]  den,
    input  logic [TAG_W-1:0]         tag,
    output logic                     out_valid,
    output logic signed [NUM_W:0]    quo,
    output logic [TAG_W-1:0]         out_tag
);

    localparam int unsigned RW = NUM_W + DEN_W + 1;

    logic [NUM_W-1:0]  q_reg   [NUM_W+1];
    logic [RW-1:0]     r_reg   [NUM_W+1];
    logic [DEN_W-1:0]  d_reg   [NUM_W+1];
    logic              neg_reg [NUM_W+1];
    logic              v_reg   [NUM_W+1];
    logic [TAG_W-1:0]  t_reg   [NUM_W+1];

    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;

    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NUM_W; i++)
                v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= NUM_W; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg[0]   <= num_mag;
            r_reg[0]   <= '0;
            d_reg[0]   <= den_mag;
            neg_reg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
            t_reg[0]   <= tag;
            for (int i = 1; i <= NUM_W; i++)
            begin
                logic [RW-1:0] sh;
                sh = {r_reg[i-1][RW-2:0], q_reg[i-1][NUM_W-1]};
                if (sh >= RW'(d_reg[i-1]))
                begin
                    r_reg[i] <= sh - RW'(d_reg[i-1]);
                    q_reg[i] <= {q_reg[i-1][NUM_W-2:0], 1'b1};
                end
                else
                begin
                    r_reg[i] <= sh;
                    q_reg[i] <= {q_reg[i-1][NUM_W-2:0], 1'b0};
                end
                d_reg[i]   <= d_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                t_reg[i]   <= t_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[NUM_W];
    assign out_tag   = t_reg[NUM_W];
    assign quo = neg_reg[NUM_W] ? -$signed({1'b0, q_reg[NUM_W]})
                                : $signed({1'b0, q_reg[NUM_W]});

endmodule

### rtl/core/triangle_transform_cull_project_top.sv
// top level: rotate, backface cull and perspective project of one triangle per cycle
// pipeline: 6 front stages, 49 divider stages (input register plus 48 quotient bits),
// then 1 output register, 56 register stages in all
// throughput: one triangle per cycle; the whole pipe advances unless the output
// holds a result and stall is high; the output register keeps accepting while empty
// reset: asynchronous active low; clears all valid bits and loads register defaults
module triangle_transform_cull_project_top #(
    parameter int unsigned SCREEN_W = ttcp_pkg::SCREEN_W_DEF,
    parameter int unsigned SCREEN_H = ttcp_pkg::SCREEN_H_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ttcp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_data,
    // triangle input
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [15:0]                a_x,
    input  logic signed [15:0]                a_y,
    input  logic signed [15:0]                a_z,
    input  logic signed [15:0]                b_x,
    input  logic signed [15:0]                b_y,
    input  logic signed [15:0]                b_z,
    input  logic signed [15:0]                c_x,
    input  logic signed [15:0]                c_y,
    input  logic signed [15:0]                c_z,
    // result output
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              visible,
    output logic signed [15:0]                a_px,
    output logic signed [15:0]                a_py,
    output logic signed [15:0]                b_px,
    output logic signed [15:0]                b_py,
    output logic signed [15:0]                c_px,
    output logic signed [15:0]                c_py
);

    localparam int unsigned ROT_W = ttcp_pkg::ROT_W;
    localparam int unsigned Z_W   = ttcp_pkg::Z_W;
    localparam int unsigned NUM_W = 48;
    localparam int unsigned DEN_W = Z_W + 14;

    // config registers
    logic signed [15:0] cos_z_reg, sin_z_reg, cos_x_reg, sin_x_reg;
    logic signed [15:0] px_reg, py_reg, depth_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_z_reg <= ttcp_pkg::COS_Z_RST;
            sin_z_reg <= ttcp_pkg::SIN_Z_RST;
            cos_x_reg <= ttcp_pkg::COS_X_RST;
            sin_x_reg <= ttcp_pkg::SIN_X_RST;
            px_reg    <= ttcp_pkg::PROJ_X_RST;
            py_reg    <= ttcp_pkg::PROJ_Y_RST;
            depth_reg <= ttcp_pkg::DEPTH_RST;
        end
        else if (cfg_valid)
        begin
            case (ttcp_pkg::cfg_reg_t'(cfg_index))
                ttcp_pkg::REG_COS_Z:  cos_z_reg <= cfg_data;
                ttcp_pkg::REG_SIN_Z:  sin_z_reg <= cfg_data;
                ttcp_pkg::REG_COS_X:  cos_x_reg <= cfg_data;
                ttcp_pkg::REG_SIN_X:  sin_x_reg <= cfg_data;
                ttcp_pkg::REG_PROJ_X: px_reg    <= cfg_data;
                ttcp_pkg::REG_PROJ_Y: py_reg    <= cfg_data;
                ttcp_pkg::REG_DEPTH:  depth_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: pipe moves whenever the output register can take a result
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // stage 1: z rotation products
    logic               v1_reg;
    logic signed [31:0] p1a_reg [3], p1b_reg [3], p1c_reg [3], p1d_reg [3];
    logic signed [15:0] z1_reg [3];
    logic signed [15:0] ix [3], iy [3], iz [3];

    assign ix = '{a_x, b_x, c_x};
    assign iy = '{a_y, b_y, c_y};
    assign iz = '{a_z, b_z, c_z};

    // stage 2: rounded xr, yr
    logic               v2_reg;
    logic signed [ROT_W-1:0] xr2_reg [3], yr2_reg [3];
    logic signed [15:0] z2_reg [3];

    // stage 3: x rotation products
    logic               v3_reg;
    logic signed [ROT_W-1:0] xr3_reg [3];
    logic signed [34:0] q3a_reg [3], q3b_reg [3], q3c_reg [3], q3d_reg [3];

    // stage 4: rotated vertex, depth applied
    logic               v4_reg;
    logic signed [ROT_W-1:0] vx4_reg [3], vy4_reg [3];
    logic signed [Z_W-1:0]   vz4_reg [3];

    // stage 5: cross product terms and projection products
    logic               v5_reg;
    logic signed [2*ROT_W+1:0] c5a_reg, c5b_reg;
    logic signed [ROT_W+15:0]  pr5x_reg [3], pr5y_reg [3];
    logic signed [Z_W-1:0]     vz5_reg [3];

    // stage 6: numerators and denominators
    logic               v6_reg;
    logic               vis6_reg;
    logic signed [NUM_W-1:0] n6_reg [6];
    logic signed [DEN_W-1:0] d6_reg [6];

    function automatic logic signed [ROT_W-1:0] rnd14(input logic signed [33:0] s);
        logic signed [33:0] t;
        begin
            t = s + 34'sd8192;
            return ROT_W'(t >>> 14);
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p1a_reg[k] <= 32'(ix[k]) * 32'(cos_z_reg);
                p1b_reg[k] <= 32'(iy[k]) * 32'(sin_z_reg);
                p1c_reg[k] <= 32'(ix[k]) * 32'(sin_z_reg);
                p1d_reg[k] <= 32'(iy[k]) * 32'(cos_z_reg);
                z1_reg[k]  <= iz[k];

                xr2_reg[k] <= rnd14(34'(p1a_reg[k]) - 34'(p1b_reg[k]));
                yr2_reg[k] <= rnd14(34'(p1c_reg[k]) + 34'(p1d_reg[k]));
                z2_reg[k]  <= z1_reg[k];

                xr3_reg[k] <= xr2_reg[k];
                q3a_reg[k] <= 35'(yr2_reg[k]) * 35'(cos_x_reg);
                q3b_reg[k] <= 35'(z2_reg[k]) * 35'(sin_x_reg);
                q3c_reg[k] <= 35'(yr2_reg[k]) * 35'(sin_x_reg);
                q3d_reg[k] <= 35'(z2_reg[k]) * 35'(cos_x_reg);

                vx4_reg[k] <= xr3_reg[k];
                vy4_reg[k] <= rnd14(34'(q3a_reg[k] - q3b_reg[k]));
                vz4_reg[k] <= Z_W'(rnd14(34'(q3c_reg[k] + q3d_reg[k])))
                              + Z_W'(depth_reg);

                pr5x_reg[k] <= (ROT_W+16)'(vx4_reg[k]) * (ROT_W+16)'(px_reg);
                pr5y_reg[k] <= (ROT_W+16)'(vy4_reg[k]) * (ROT_W+16)'(py_reg);
                vz5_reg[k]  <= vz4_reg[k];
            end
            // cross product z of (B-A) x (C-A)
            c5a_reg <= (2*ROT_W+2)'(vx4_reg[1] - vx4_reg[0])
                     * (2*ROT_W+2)'(vy4_reg[2] - vy4_reg[0]);
            c5b_reg <= (2*ROT_W+2)'(vy4_reg[1] - vy4_reg[0])
                     * (2*ROT_W+2)'(vx4_reg[2] - vx4_reg[0]);

            vis6_reg <= (c5a_reg < c5b_reg);
            for (int k = 0; k < 3; k++)
            begin
                logic signed [NUM_W-1:0] bx, by;
                // zero depth: divide by 2^25 with 2^24 bias
                if (vz5_reg[k] == '0)
                begin
                    bx = NUM_W'(pr5x_reg[k]) + (NUM_W'(1) <<< 24);
                    by = NUM_W'(pr5y_reg[k]) + (NUM_W'(1) <<< 24);
                    d6_reg[2*k]   <= DEN_W'(1) <<< 25;
                    d6_reg[2*k+1] <= DEN_W'(1) <<< 25;
                end
                else
                begin
                    bx = NUM_W'(pr5x_reg[k]) + (NUM_W'(vz5_reg[k]) <<< 12);
                    by = NUM_W'(pr5y_reg[k]) + (NUM_W'(vz5_reg[k]) <<< 12);
                    d6_reg[2*k]   <= DEN_W'(vz5_reg[k]) <<< 13;
                    d6_reg[2*k+1] <= DEN_W'(vz5_reg[k]) <<< 13;
                end
                n6_reg[2*k]   <= bx * $signed(NUM_W'(SCREEN_W));
                n6_reg[2*k+1] <= by * $signed(NUM_W'(SCREEN_H));
            end
        end
    end

    // six dividers in lock step; the visible flag rides along as the tag
    logic               dv_valid [6];
    logic               dv_vis   [6];
    logic signed [NUM_W:0] dv_quo [6];

    for (genvar g = 0; g < 6; g++)
    begin : g_div
        ttcp_div #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W),
            .TAG_W (1)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (v6_reg),
            .num       (n6_reg[g]),
            .den       (d6_reg[g]),
            .tag       (vis6_reg),
            .out_valid (dv_valid[g]),
            .quo       (dv_quo[g]),
            .out_tag   (dv_vis[g])
        );
    end

    // output register, culled triangles give zero pixels
    logic               ov_reg;
    logic               vis_reg;
    logic signed [15:0] pix_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= dv_valid[0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vis_reg <= dv_vis[0];
            for (int k = 0; k < 6; k++)
                pix_reg[k] <= dv_vis[0] ? ttcp_pkg::sat16(48'(dv_quo[k])) : 16'sd0;
        end
    end

    assign out_valid = ov_reg;
    assign visible   = vis_reg;
    assign a_px = pix_reg[0];
    assign a_py = pix_reg[1];
    assign b_px = pix_reg[2];
    assign b_py = pix_reg[3];
    assign c_px = pix_reg[4];
    assign c_py = pix_reg[5];

endmodule
